// ===== rtl/core/gcms_pkg.sv =====
// shared types and constants of the gradient colour map sampler
package gcms_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int POS_W        = FRAC_BITS + 1;
   localparam int COL_W        = 32;
   localparam int MAX_STOPS_DEF = 8;
   localparam int MIN_SPAN     = 7;

   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_ANIM   = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [2:0] REG_STOP_COUNT  = 3'd0;
   localparam logic [2:0] REG_BEAT_ENABLE = 3'd1;
   localparam logic [2:0] REG_BRIGHT_LOW  = 3'd2;
   localparam logic [2:0] REG_BRIGHT_HIGH = 3'd3;
   localparam logic [2:0] REG_ANIM_SPEED  = 3'd4;
   localparam logic [2:0] REG_ANIM_OFFSET = 3'd5;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] u;
      logic [POS_W-1:0] lo_pos;
      logic [POS_W-1:0] hi_pos;
      logic [POS_W-1:0] first_pos;
      logic [POS_W-1:0] last_pos;
      logic [COL_W-1:0] lo_col;
      logic [COL_W-1:0] hi_col;
      logic [COL_W-1:0] first_col;
      logic [COL_W-1:0] last_col;
   } gcms_qry_type;

endpackage

// ===== rtl/core/gcms_cell.sv =====
// one stop cell: holds a stop and checks the passing query against it and its neighbour
module gcms_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [2:0]                    wr_idx,
   input  logic [gcms_pkg::POS_W-1:0]    wr_pos,
   input  logic [gcms_pkg::COL_W-1:0]    wr_col,
   input  logic [CNT_W-1:0]              n,
   input  logic [gcms_pkg::POS_W-1:0]    nxt_pos,
   input  logic [gcms_pkg::COL_W-1:0]    nxt_col,
   input  gcms_pkg::gcms_qry_type        qry_in,
   output gcms_pkg::gcms_qry_type        qry_out,
   output logic [gcms_pkg::POS_W-1:0]    pos,
   output logic [gcms_pkg::COL_W-1:0]    col
);
   import gcms_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [COL_W-1:0] col_ff;
   gcms_qry_type     qry_ff, qry_in_c;
   logic             pair_ok, hit;

   always_ff @(posedge clock) begin
      if (wr_en && (int'(wr_idx) == IDX)) begin
         pos_ff <= wr_pos;
         col_ff <= wr_col;
      end
   end

   always_comb begin
      qry_in_c = qry_in;
      pair_ok  = n > CNT_W'(IDX + 1);
      hit      = pair_ok && !qry_in.found && (qry_in.u >= pos_ff) && (qry_in.u <= nxt_pos);
      if (IDX == 0) begin
         qry_in_c.first_pos = pos_ff;
         qry_in_c.first_col = col_ff;
      end
      if (n == CNT_W'(IDX + 1)) begin
         qry_in_c.last_pos = pos_ff;
         qry_in_c.last_col = col_ff;
      end
      if (hit) begin
         qry_in_c.found  = 1'b1;
         qry_in_c.lo_pos = pos_ff;
         qry_in_c.lo_col = col_ff;
         qry_in_c.hi_pos = nxt_pos;
         qry_in_c.hi_col = nxt_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qry_ff.valid <= 1'b0;
      end else begin
         qry_ff.valid <= qry_in_c.valid;
      end
      qry_ff.found     <= qry_in_c.found;
      qry_ff.u         <= qry_in_c.u;
      qry_ff.lo_pos    <= qry_in_c.lo_pos;
      qry_ff.hi_pos    <= qry_in_c.hi_pos;
      qry_ff.first_pos <= qry_in_c.first_pos;
      qry_ff.last_pos  <= qry_in_c.last_pos;
      qry_ff.lo_col    <= qry_in_c.lo_col;
      qry_ff.hi_col    <= qry_in_c.hi_col;
      qry_ff.first_col <= qry_in_c.first_col;
      qry_ff.last_col  <= qry_in_c.last_col;
   end

   assign qry_out = qry_ff;
   assign pos     = pos_ff;
   assign col     = col_ff;

endmodule

// ===== rtl/core/gcms_div.sv =====
// restoring divider, one quotient bit a cycle, for the local fraction
module gcms_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gcms_pkg::POS_W-1:0] dividend,
   input  logic [gcms_pkg::POS_W-1:0] divisor,
   output logic                       done,
   output logic [gcms_pkg::POS_W-1:0] quotient
);
   import gcms_pkg::*;

   localparam int CW = $clog2(POS_W + 1);

   logic [POS_W:0]   rem_ff, rem_in, rem_sub, rem_sel;
   logic [POS_W-1:0] quo_ff, quo_in, div_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff, ge;

   always_comb begin
      ge      = rem_ff >= {1'b0, div_ff};
      rem_sub = rem_ff - {1'b0, div_ff};
      rem_sel = ge ? rem_sub : rem_ff;
      rem_in  = {rem_sel[POS_W-1:0], 1'b0};
      quo_in  = {quo_ff[POS_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CW'(1))) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         rem_ff <= {1'b0, dividend};
         div_ff <= divisor;
         quo_ff <= '0;
         cnt_ff <= CW'(POS_W);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/gradient_color_map_sampler_unit.sv =====
// top level of the gradient colour map sampler
// Write-stop and tick items take effect at the edge they are accepted and give no result,
// so they can follow each other in every cycle. A sample item walks a query through the row
// of MAX_STOPS stop cells, one cell a cycle, and the stop pair is picked at the tail of the
// row in the cycle the last cell hands the query on. The serial divider follows when the
// span is wide enough and the position lies inside it. The four channels are then blended
// and modulated one after another, the result register is loaded, and the block returns to
// idle to take the next item; it takes no new item while a sample is under way. The result
// register lets the next item in while a result waits. A result that is still waiting there
// holds the next sample in its load cycle until the receiver takes it.
module gradient_color_map_sampler_unit #(
   parameter int MAX_STOPS = gcms_pkg::MAX_STOPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_command,
   input  logic [2:0]                 req_stop_index,
   input  logic [16:0]                req_stop_position,
   input  logic [7:0]                 req_stop_red,
   input  logic [7:0]                 req_stop_green,
   input  logic [7:0]                 req_stop_blue,
   input  logic [7:0]                 req_stop_alpha,
   input  logic signed [17:0]         req_position,
   input  logic [8:0]                 req_beat_intensity,
   input  logic [15:0]                req_delta_time,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue,
   output logic [7:0]                 rsp_alpha,
   input  logic                       csr_write_enable,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_write_data
);
   import gcms_pkg::*;

   localparam int CNT_W = $clog2(MAX_STOPS + 1) > 4 ? $clog2(MAX_STOPS + 1) : 4;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_INTERP = 3'd3;
   localparam logic [2:0] S_MOD    = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   // configuration registers
   logic [3:0]  stop_count_ff;
   logic        beat_enable_ff;
   logic [9:0]  bright_low_ff, bright_high_ff;
   logic [15:0] anim_speed_ff, anim_offset_ff;
   logic [15:0] phase_ff, phase_in;

   logic [2:0]  state_ff, state_in;
   logic        accept, is_sample;

   // per-item working registers
   logic [8:0]        inten_ff;
   logic              mod_ff;
   logic [18:0]       gain_ff;
   logic [COL_W-1:0]  lo_col_ff, hi_col_ff;
   logic [POS_W-1:0]  frac_ff;
   logic [1:0]        chan_ff;
   logic [7:0]        c_ff;
   logic [7:0]        res_ff [4];
   logic              rsp_valid_ff;
   logic [7:0]        out_ff [4];

   logic [CNT_W-1:0]  n_sat;
   logic [POS_W-1:0]  wr_pos_sat, u_c;
   logic [COL_W-1:0]  wr_col;
   logic [31:0]       tick_prod;
   logic signed [19:0] sum_s;
   logic signed [18:0] t_c;

   gcms_qry_type      qry [MAX_STOPS+1];
   logic [POS_W-1:0]  cell_pos [MAX_STOPS];
   logic [COL_W-1:0]  cell_col [MAX_STOPS];

   gcms_qry_type      qo;
   logic              pick_first, pick_last, use_div;
   logic [POS_W-1:0]  sel_lo_pos, sel_hi_pos;
   logic [COL_W-1:0]  sel_lo_col, sel_hi_col;
   logic              div_done;
   logic [POS_W-1:0]  div_q;

   logic [8:0]        inten_sat;
   logic [18:0]       gain_c;
   logic [7:0]        ch_a, ch_b;
   logic [25:0]       blend;
   logic [26:0]       modp;
   logic [7:0]        mod_c;
   logic              load_out;

   assign accept    = req_valid && req_ready;
   assign is_sample = (req_command == CMD_SAMPLE) || (req_command == CMD_ANIM);
   assign req_ready = (state_ff == S_IDLE);

   // stop count saturated into the usable range
   always_comb begin
      if (stop_count_ff < 4'd2) begin
         n_sat = CNT_W'(2);
      end else if (CNT_W'(stop_count_ff) > CNT_W'(MAX_STOPS)) begin
         n_sat = CNT_W'(MAX_STOPS);
      end else begin
         n_sat = CNT_W'(stop_count_ff);
      end
   end

   always_comb begin
      wr_pos_sat = (req_stop_position > POS_ONE) ? POS_ONE : req_stop_position;
      wr_col     = {req_stop_red, req_stop_green, req_stop_blue, req_stop_alpha};
   end

   // tick: truncated phase increment, wrap at one
   always_comb begin
      tick_prod = req_delta_time * anim_speed_ff;
      phase_in  = phase_ff + tick_prod[23:8];
   end

   // sample position: animated items shift and wrap (a negative sum gives zero), then clamp to [0, one]
   always_comb begin
      sum_s = 20'(req_position) + $signed({4'b0, phase_ff}) + $signed({4'b0, anim_offset_ff});
      if (req_command == CMD_ANIM) begin
         t_c = sum_s[19] ? 19'sd0 : $signed({3'b0, sum_s[15:0]});
      end else begin
         t_c = 19'(req_position);
      end
      if (t_c[18]) begin
         u_c = '0;
      end else if (t_c[17:0] > 18'(POS_ONE)) begin
         u_c = POS_ONE;
      end else begin
         u_c = t_c[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff  <= 4'd2;
         beat_enable_ff <= 1'b0;
         bright_low_ff  <= 10'd256;
         bright_high_ff <= 10'd256;
         anim_speed_ff  <= '0;
         anim_offset_ff <= '0;
         phase_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_STOP_COUNT:  stop_count_ff  <= csr_write_data[3:0];
               REG_BEAT_ENABLE: beat_enable_ff <= csr_write_data[0];
               REG_BRIGHT_LOW:  bright_low_ff  <= csr_write_data[9:0];
               REG_BRIGHT_HIGH: bright_high_ff <= csr_write_data[9:0];
               REG_ANIM_SPEED:  anim_speed_ff  <= csr_write_data;
               REG_ANIM_OFFSET: anim_offset_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (accept && (req_command == CMD_TICK) && (anim_speed_ff != '0)) begin
            phase_ff <= phase_in;
         end
      end
   end

   // query injected at the head of the cell row
   always_comb begin
      qry[0]       = '0;
      qry[0].valid = accept && is_sample;
      qry[0].u     = u_c;
   end

   for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
      logic [POS_W-1:0] nxt_pos;
      logic [COL_W-1:0] nxt_col;
      if (i + 1 < MAX_STOPS) begin : g_nxt
         assign nxt_pos = cell_pos[i+1];
         assign nxt_col = cell_col[i+1];
      end else begin : g_end
         assign nxt_pos = '0;
         assign nxt_col = '0;
      end
      gcms_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (accept && (req_command == CMD_WRITE)),
         .wr_idx  (req_stop_index),
         .wr_pos  (wr_pos_sat),
         .wr_col  (wr_col),
         .n       (n_sat),
         .nxt_pos (nxt_pos),
         .nxt_col (nxt_col),
         .qry_in  (qry[i]),
         .qry_out (qry[i+1]),
         .pos     (cell_pos[i]),
         .col     (cell_col[i])
      );
   end

   // pair selection at the tail of the row
   always_comb begin
      qo         = qry[MAX_STOPS];
      pick_first = qo.u <= qo.first_pos;
      pick_last  = qo.u >= qo.last_pos;
      sel_lo_pos = qo.found ? qo.lo_pos : qo.first_pos;
      sel_hi_pos = qo.found ? qo.hi_pos : qo.last_pos;
      sel_lo_col = qo.found ? qo.lo_col : qo.first_col;
      sel_hi_col = qo.found ? qo.hi_col : qo.last_col;
      if (pick_first) begin
         sel_lo_col = qo.first_col;
         sel_hi_col = qo.first_col;
      end else if (pick_last) begin
         sel_lo_col = qo.last_col;
         sel_hi_col = qo.last_col;
      end
      // narrow span keeps the lower colour
      use_div = !pick_first && !pick_last &&
                ({1'b0, sel_hi_pos} >= {1'b0, sel_lo_pos} + (POS_W+1)'(MIN_SPAN)) &&
                (qo.u >= sel_lo_pos);
   end

   gcms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == S_SEARCH) && qo.valid && use_div),
      .dividend (qo.u - sel_lo_pos),
      .divisor  (sel_hi_pos - sel_lo_pos),
      .done     (div_done),
      .quotient (div_q)
   );

   // brightness gain, Q2.16
   always_comb begin
      inten_sat = (inten_ff > 9'd256) ? 9'd256 : inten_ff;
      gain_c    = {9'd0, bright_low_ff} * {10'd0, 9'd256 - inten_sat} +
                  {9'd0, bright_high_ff} * {10'd0, inten_sat};
   end

   // one channel at a time: blend, then modulate all channels but alpha
   always_comb begin
      ch_a  = lo_col_ff[8*(3-chan_ff) +: 8];
      ch_b  = hi_col_ff[8*(3-chan_ff) +: 8];
      blend = {18'd0, ch_a} * {9'd0, POS_ONE - frac_ff} +
              {18'd0, ch_b} * {9'd0, frac_ff} + 26'd32768;
      modp  = {19'd0, c_ff} * {8'd0, gain_ff} + 27'd32768;
      if (mod_ff && (chan_ff != 2'd3)) begin
         mod_c = (modp[26:16] > 11'd255) ? 8'd255 : modp[23:16];
      end else begin
         mod_c = c_ff;
      end
   end

   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept && is_sample) state_in = S_SEARCH;
         S_SEARCH: if (qo.valid) state_in = use_div ? S_DIV : S_INTERP;
         S_DIV:    if (div_done) state_in = S_INTERP;
         S_INTERP: state_in = S_MOD;
         S_MOD:    state_in = (chan_ff == 2'd3) ? S_DONE : S_INTERP;
         S_DONE:   if (load_out) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_sample) begin
         inten_ff <= req_beat_intensity;
         mod_ff   <= beat_enable_ff && (req_beat_intensity != '0);
      end
      if (state_ff == S_SEARCH) begin
         gain_ff <= gain_c;
      end
      if ((state_ff == S_SEARCH) && qo.valid) begin
         lo_col_ff <= sel_lo_col;
         hi_col_ff <= sel_hi_col;
         frac_ff   <= '0;
         chan_ff   <= 2'd0;
      end
      if ((state_ff == S_DIV) && div_done) begin
         frac_ff <= (div_q > POS_ONE) ? POS_ONE : div_q;
      end
      if (state_ff == S_INTERP) begin
         c_ff <= blend[23:16];
      end
      if (state_ff == S_MOD) begin
         res_ff[chan_ff] <= mod_c;
         chan_ff         <= chan_ff + 2'd1;
      end
      if (load_out) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = out_ff[0];
   assign rsp_green = out_ff[1];
   assign rsp_blue  = out_ff[2];
   assign rsp_alpha = out_ff[3];

endmodule

// ===== rtl/core/gcms_checker.sv =====
// port-level checks on the sampler, bound to the top level
module gcms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_alpha
);
   import gcms_pkg::*;

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_alpha))
      else $error("result changed while stalled");

   // reset leaves no result behind
   a_rst_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // writes and ticks make no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid &&
      (req_command == CMD_WRITE || req_command == CMD_TICK) |=> !rsp_valid)
      else $error("result from an item that gives none");

   // a sample occupies the block
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_command == CMD_SAMPLE || req_command == CMD_ANIM) |=> !req_ready)
      else $error("new item taken during a sample");

endmodule

bind gradient_color_map_sampler_unit gcms_checker u_gcms_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_red     (rsp_red),
   .rsp_alpha   (rsp_alpha)
);
